[rtl/nar_pkg.sv]
// shared types, constants and command codes for the accumulator row update core
`timescale 1ns / 1ps
`default_nettype none

package nar_pkg;

   // sizing
   localparam int CHANNELS = 256;
   localparam int FEATURES = 8192;
   localparam int CH_W     = $clog2(CHANNELS);
   localparam int CHX_W    = 16;
   localparam int IDX_W    = 13;
   localparam int RCH_W    = 8;
   localparam int CMD_W    = 2;
   localparam int SUM_W    = 32;
   localparam int PROD_W   = 21;

   localparam logic [CH_W-1:0]  CH_LAST    = CH_W'(CHANNELS - 1);
   localparam logic [CHX_W-1:0] CH_LIMIT   = CHX_W'(CHANNELS);
   localparam logic [IDX_W:0]   FEAT_LIMIT = (IDX_W + 1)'(FEATURES);

   // hash constants
   localparam logic [31:0] HASH_A = 32'h9e37_79b9;
   localparam logic [31:0] HASH_B = 32'h85eb_ca6b;
   localparam logic [31:0] HASH_C = 32'h7feb_352d;
   localparam logic [31:0] W_BIAS = 32'd32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPLY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // sequencer to lane control
   typedef struct packed {
      logic             start;
      logic             issue;
      logic             clear;
      logic             add_row;
      logic [IDX_W-1:0] index;
      logic [CH_W-1:0]  addr;
   } lane_ctrl_type;

endpackage

`default_nettype wire

[rtl/nar_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module nar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/nar_lane.sv]
// one side's lane: weight hash pipeline and read-modify-write of its sum ram
`timescale 1ns / 1ps
`default_nettype none

module nar_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  nar_pkg::lane_ctrl_type      ctrl,
   output logic [nar_pkg::SUM_W-1:0]   rd_data
);
   import nar_pkg::*;

   logic [31:0]       idx_mul_ff, idx_mul_in;
   logic [31:0]       chk_ff, chk_in;
   logic              en_ff, en_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              wv_ff, wv_in;
   logic              wclr_ff;
   logic              wadd_ff;
   logic [CH_W-1:0]   waddr_ff;

   logic [31:0]       mix0;
   logic [31:0]       mix;
   logic [31:0]       prod_full;
   logic [5:0]        wbits;
   logic [SUM_W-1:0]  weight;
   logic [SUM_W-1:0]  sum_new;
   logic [SUM_W-1:0]  wr_data;

   // row setup and per-channel hash, one multiplier per stage
   always_comb begin
      idx_mul_in = idx_mul_ff;
      chk_in     = chk_ff;
      en_in      = en_ff;
      if (ctrl.start) begin
         idx_mul_in = 32'(ctrl.index) * HASH_A;
         chk_in     = HASH_B;
         en_in      = ({1'b0, ctrl.index} < FEAT_LIMIT);
      end else if (ctrl.issue) begin
         chk_in = chk_ff + HASH_B;
      end
      mix0      = idx_mul_ff ^ chk_ff;
      mix       = mix0 ^ (mix0 >> 16);
      prod_full = mix * HASH_C;
      prod_in   = prod_full[PROD_W-1:0];
      wv_in     = ctrl.issue & (ctrl.clear | en_ff);
   end

   // write stage: weight in -32..31, wrapping add or subtract, or zero on a clear
   always_comb begin
      wbits   = prod_ff[5:0] ^ prod_ff[20:15];
      weight  = 32'(wbits) - W_BIAS;
      sum_new = wadd_ff ? (rd_data + weight) : (rd_data - weight);
      wr_data = wclr_ff ? '0 : sum_new;
   end

   always_ff @(posedge clock) begin
      idx_mul_ff <= idx_mul_in;
      chk_ff     <= chk_in;
      prod_ff    <= prod_in;
      wclr_ff    <= ctrl.clear;
      wadd_ff    <= ctrl.add_row;
      waddr_ff   <= ctrl.addr;
      if (reset) begin
         en_ff <= 1'b0;
         wv_ff <= 1'b0;
      end else begin
         en_ff <= en_in;
         wv_ff <= wv_in;
      end
   end

   nar_ram #(
      .WIDTH(SUM_W),
      .DEPTH(CHANNELS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wv_ff),
      .wr_addr(waddr_ff),
      .wr_data(wr_data),
      .rd_addr(ctrl.addr),
      .rd_data(rd_data)
   );

endmodule

`default_nettype wire

[rtl/nnue_accumulator_row_update_core.sv]
// top level: sequencer and two side lanes of the accumulator row update
//
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  command, black/white index, add_row, read side/channel
// rsp      out        rsp_valid / rsp_stall  sum_value
//
// an apply transaction sweeps the channels one channel per cycle through each
// side's hash multiplier and the read-modify-write port of its sum ram, both sides at once
// a clear transaction sweeps both rams with zeros, then drains like an apply
// a read transaction passes through the registered ram read, then waits while the
// result register is still held by rsp_stall; unused command codes are accepted and ignored
// after reset the same clearing pass runs before req_stall drops
// req_stall is high whenever a transaction is in progress; rsp_stall only holds the result
`timescale 1ns / 1ps
`default_nettype none

module nnue_accumulator_row_update_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [nar_pkg::CMD_W-1:0]          req_command,
   input  logic [nar_pkg::IDX_W-1:0]          req_black_index,
   input  logic [nar_pkg::IDX_W-1:0]          req_white_index,
   input  logic                               req_add_row,
   input  logic                               req_read_side,
   input  logic [nar_pkg::RCH_W-1:0]          req_read_channel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nar_pkg::SUM_W-1:0]   rsp_sum_value
);
   import nar_pkg::*;

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_READ,
      ST_RESP_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic             add_ff, add_in;
   logic             side_ff, side_in;
   logic             rng_ff, rng_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic             req_accept;
   logic             rsp_free;
   logic [CHX_W-1:0] rd_ch_ext;
   lane_ctrl_type    ctrl_base;
   lane_ctrl_type    ctrl_black;
   lane_ctrl_type    ctrl_white;
   logic [SUM_W-1:0] rd_black;
   logic [SUM_W-1:0] rd_white;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;
   assign rd_ch_ext  = CHX_W'(req_read_channel);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      add_in       = add_ff;
      side_in      = side_ff;
      rng_in       = rng_ff;
      rsp_sum_in   = rsp_sum_ff;
      // result register empties when the consumer takes it
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      ctrl_base         = '0;
      ctrl_base.add_row = add_ff;
      ctrl_base.addr    = ch_ff;

      unique case (state_ff)
         ST_WIPE: begin
            ctrl_base.issue = 1'b1;
            ctrl_base.clear = 1'b1;
            ch_in           = CH_W'(ch_ff + 1'b1);
            if (ch_ff == CH_LAST) begin
               ch_in    = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_command)
                  CMD_CLEAR: begin
                     ch_in    = '0;
                     state_in = ST_WIPE;
                  end
                  CMD_APPLY: begin
                     // lanes latch index product and range check here
                     ctrl_base.start = 1'b1;
                     add_in          = req_add_row;
                     ch_in           = '0;
                     state_in        = ST_RUN;
                  end
                  CMD_READ: begin
                     ch_in    = rd_ch_ext[CH_W-1:0];
                     side_in  = req_read_side;
                     rng_in   = (rd_ch_ext < CH_LIMIT);
                     state_in = ST_READ;
                  end
                  default: begin
                     // unused code: nothing to do
                  end
               endcase
            end
         end
         ST_RUN: begin
            ctrl_base.issue = 1'b1;
            ch_in           = CH_W'(ch_ff + 1'b1);
            if (ch_ff == CH_LAST) begin
               ch_in    = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last channel's write lands at the end of this cycle
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_RESP_WAIT;
         end
         ST_RESP_WAIT: begin
            // ram data holds while the address stays put
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = rng_ff ? (side_ff ? rd_white : rd_black) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // per-side control differs only in the row index
   always_comb begin
      ctrl_black       = ctrl_base;
      ctrl_white       = ctrl_base;
      ctrl_black.index = req_black_index;
      ctrl_white.index = req_white_index;
   end

   always_ff @(posedge clock) begin
      add_ff     <= add_in;
      side_ff    <= side_in;
      rng_ff     <= rng_in;
      rsp_sum_ff <= rsp_sum_in;
      if (reset) begin
         state_ff     <= ST_WIPE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_value = $signed(rsp_sum_ff);

   // first side
   nar_lane u_lane_black (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl_black),
      .rd_data(rd_black)
   );

   // second side
   nar_lane u_lane_white (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl_white),
      .rd_data(rd_white)
   );

`ifndef NO_ASSERTIONS
   // a result only appears out of the read wait state
   a_rsp_from_read : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP_WAIT))
      else $error("result raised outside a read");

   // a read beyond the channel count returns zero
   a_rsp_out_of_range : assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(rng_ff)) |-> (rsp_sum_ff == '0))
      else $error("out of range read returned non-zero");

   // the row sweep ends on the last channel and then drains
   a_run_to_drain : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && (ch_ff == CH_LAST)) |=> (state_ff == ST_DRAIN))
      else $error("row sweep did not end at the last channel");
`endif

endmodule

`default_nettype wire

[bench/nar_sum_checker.sv]
// checker for the accumulator row update core: watches both channels, predicts and compares
`timescale 1ns / 1ps

module nar_sum_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [nar_pkg::CMD_W-1:0]          req_command,
   input  logic [nar_pkg::IDX_W-1:0]          req_black_index,
   input  logic [nar_pkg::IDX_W-1:0]          req_white_index,
   input  logic                               req_add_row,
   input  logic                               req_read_side,
   input  logic [nar_pkg::RCH_W-1:0]          req_read_channel,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [nar_pkg::SUM_W-1:0]   rsp_sum_value,
   output int                                 mismatches,
   output int                                 outstanding,
   output int                                 results_checked
);
   import nar_pkg::*;

   localparam logic [31:0] MIX_A       = 32'h9e37_79b9;
   localparam logic [31:0] MIX_B       = 32'h85eb_ca6b;
   localparam logic [31:0] MIX_C       = 32'h7feb_352d;
   localparam logic [31:0] WEIGHT_BIAS = 32'd32;

   // predicted accumulator contents, side 0 is black, side 1 is white
   logic [SUM_W-1:0]        side_sums_q [2][CHANNELS];
   logic signed [SUM_W-1:0] expected_sums [$];
   logic signed [SUM_W-1:0] want;

   // weight of one channel of a feature row, in -32..31 as a 32-bit pattern
   function automatic logic [31:0] hash_weight(input logic [IDX_W-1:0] index,
                                               input int unsigned channel);
      logic [31:0] u;
      u = ({19'd0, index} * MIX_A) ^ ((channel + 32'd1) * MIX_B);
      u ^= u >> 16;
      u = u * MIX_C;
      u ^= u >> 15;
      return (u & 32'd63) - WEIGHT_BIAS;
   endfunction

   task automatic apply_feature_row(input int side, input logic [IDX_W-1:0] index,
                                    input logic add);
      logic [31:0] w;
      if (int'(index) >= FEATURES) return;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         w = hash_weight(index, ch);
         side_sums_q[side][ch] = add ? side_sums_q[side][ch] + w : side_sums_q[side][ch] - w;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (side_sums_q[s, c]) side_sums_q[s][c] = '0;
         expected_sums.delete();
      end else begin
         // results first: a result can never belong to the request taken at the same edge
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_sums.size() == 0) begin
               mismatches++;
               $error("sum_value: no read waiting, expected nothing, got %0d", rsp_sum_value);
            end else begin
               want = expected_sums.pop_front();
               results_checked++;
               if (rsp_sum_value !== want) begin
                  mismatches++;
                  $error("sum_value mismatch: expected %0d, got %0d", want, rsp_sum_value);
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            case (req_command)
               CMD_CLEAR: begin
                  foreach (side_sums_q[s, c]) side_sums_q[s][c] = '0;
               end
               CMD_APPLY: begin
                  apply_feature_row(0, req_black_index, req_add_row);
                  apply_feature_row(1, req_white_index, req_add_row);
               end
               CMD_READ: begin
                  if (int'(req_read_channel) < CHANNELS)
                     expected_sums.insert(expected_sums.size(),
                                          side_sums_q[req_read_side][req_read_channel]);
                  else
                     expected_sums.insert(expected_sums.size(), '0);
               end
               default: ;
            endcase
         end
      end
      outstanding <= expected_sums.size();
   end

endmodule

[bench/nnue_accumulator_row_update_core_tb.sv]
// testbench top for the accumulator row update core: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module nnue_accumulator_row_update_core_tb;
   import nar_pkg::*;

   // command code with no meaning to the core, must be ignored
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int TOTAL_ITEMS    = 900;
   // quiet cycles allowed: longer than an apply, the longest sender gap
   // and heavy result stalls, all taken several times over
   localparam int WATCHDOG_LIMIT = 5000;
   // an apply or clear gives no result, so let the last one finish before the verdict
   localparam int SETTLE_CYCLES  = CHANNELS + 16;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_type;
   typedef enum logic [2:0] {SCN_MOVE, SCN_UNDO, SCN_CLEAR, SCN_READS, SCN_NOISE} scenario_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_command = CMD_CLEAR;
   logic [IDX_W-1:0]        req_black_index = '0;
   logic [IDX_W-1:0]        req_white_index = '0;
   logic                    req_add_row = 1'b0;
   logic                    req_read_side = 1'b0;
   logic [RCH_W-1:0]        req_read_channel = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [SUM_W-1:0] rsp_sum_value;

   int mismatches;
   int outstanding;
   int results_checked;

   // sender bookkeeping
   int burst_left = 0;
   int items_sent = 0;
   int applies_sent = 0;
   int reads_sent = 0;
   int clears_sent = 0;
   int unused_sent = 0;

   // receiver stall pattern
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   int quiet_cycles = 0;

   nnue_accumulator_row_update_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_black_index  (req_black_index),
      .req_white_index  (req_white_index),
      .req_add_row      (req_add_row),
      .req_read_side    (req_read_side),
      .req_read_channel (req_read_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sum_value    (rsp_sum_value)
   );

   nar_sum_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_black_index  (req_black_index),
      .req_white_index  (req_white_index),
      .req_add_row      (req_add_row),
      .req_read_side    (req_read_side),
      .req_read_channel (req_read_channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sum_value    (rsp_sum_value),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .results_checked  (results_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: switches between no stall, coin-flip stall and heavy stall every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 2));
            stall_left <= $urandom_range(20, 200);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 1) == 1);
            default:      rsp_stall <= ($urandom_range(0, 99) < 85);
         endcase
      end
   end

   // watchdog: any stretch with no transaction on either channel that is far too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // feature index biased towards both ends of the range
   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return IDX_W'($urandom_range(0, FEATURES - 1));
      endcase
   endfunction

   // channel biased towards the first and last channel
   function automatic logic [RCH_W-1:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return RCH_W'(CHANNELS - 1);
         default: return RCH_W'($urandom_range(0, CHANNELS - 1));
      endcase
   endfunction

   // sender pacing: bursts of random length, then a gap that may be none, short or long
   // enough to outlast a whole apply, so valid rises at every phase of the core's work
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1, 2:    gap = $urandom_range(1, 8);
            default: gap = $urandom_range(9, 300);
         endcase
         if (gap > 0) begin
            // payload wanders while valid is low, the core must ignore it
            req_valid        <= 1'b0;
            req_command      <= CMD_W'($urandom_range(0, 3));
            req_black_index  <= IDX_W'($urandom);
            req_white_index  <= IDX_W'($urandom);
            req_add_row      <= 1'($urandom);
            req_read_side    <= 1'($urandom);
            req_read_channel <= RCH_W'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // one transaction, held until the core takes it; valid stays high for a following one
   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic [IDX_W-1:0] black, white,
                            input logic add, side,
                            input logic [RCH_W-1:0] ch);
      pace();
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_black_index  <= black;
      req_white_index  <= white;
      req_add_row      <= add;
      req_read_side    <= side;
      req_read_channel <= ch;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
      case (cmd)
         CMD_CLEAR: clears_sent++;
         CMD_APPLY: applies_sent++;
         CMD_READ:  reads_sent++;
         default:   unused_sent++;
      endcase
   endtask

   // read with the unused fields left random
   task automatic send_read(input logic side, input logic [RCH_W-1:0] ch);
      send_item(CMD_READ, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom), side, ch);
   endtask

   task automatic send_apply(input logic [IDX_W-1:0] black, white, input logic add);
      send_item(CMD_APPLY, black, white, add, 1'($urandom), RCH_W'($urandom));
   endtask

   // hold the sender off until every outstanding read has returned
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      scenario_type     scenario;
      logic [IDX_W-1:0] black;
      logic [IDX_W-1:0] white;
      logic             add;
      int               next_pause;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: freshly reset sums, extreme rows and channels, ignored code, undo, clear
      send_read(1'b0, '0);
      send_read(1'b1, RCH_W'(CHANNELS - 1));
      send_apply('0, '1, 1'b1);
      send_read(1'b0, '0);
      send_read(1'b0, RCH_W'(CHANNELS - 1));
      send_read(1'b1, '0);
      send_read(1'b1, RCH_W'(CHANNELS - 1));
      send_apply('1, '0, 1'b0);
      send_read(1'b0, '0);
      send_read(1'b1, RCH_W'(CHANNELS - 1));
      send_item(CMD_UNUSED, '1, '1, 1'b1, 1'b1, '1);
      send_item(CMD_UNUSED, '0, '0, 1'b0, 1'b0, '0);
      send_read(1'b1, RCH_W'(128));
      send_apply(IDX_W'(13'h1555), IDX_W'(13'h0aaa), 1'b1);
      send_apply(IDX_W'(13'h1555), IDX_W'(13'h0aaa), 1'b0);
      send_read(1'b0, RCH_W'(85));
      send_read(1'b1, RCH_W'(170));
      send_item(CMD_CLEAR, '1, '1, 1'b1, 1'b1, '1);
      send_read(1'b0, '0);
      send_read(1'b1, RCH_W'(CHANNELS - 1));
      send_apply('1, '1, 1'b1);
      send_apply('1, '1, 1'b1);
      send_read(1'b0, RCH_W'(CHANNELS - 1));
      send_read(1'b1, '0);
      wait_for_results();

      // random: mostly position-like sequences of feature changes followed by reads
      next_pause = items_sent + $urandom_range(100, 250);
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= next_pause) begin
            wait_for_results();
            next_pause = items_sent + $urandom_range(100, 250);
         end
         case ($urandom_range(0, 99)) inside
            [0:49]:  scenario = SCN_MOVE;
            [50:64]: scenario = SCN_UNDO;
            [65:72]: scenario = SCN_CLEAR;
            [73:89]: scenario = SCN_READS;
            default: scenario = SCN_NOISE;
         endcase
         case (scenario)
            SCN_MOVE: begin
               repeat ($urandom_range(1, 3)) send_apply(pick_index(), pick_index(), 1'($urandom));
               repeat ($urandom_range(1, 4)) send_read(1'($urandom), pick_channel());
            end
            SCN_UNDO: begin
               // a feature added and taken away again must leave the sums as they were
               black = pick_index();
               white = pick_index();
               add   = 1'($urandom);
               send_apply(black, white, add);
               repeat ($urandom_range(0, 2)) send_read(1'($urandom), pick_channel());
               send_apply(black, white, !add);
               repeat ($urandom_range(1, 3)) send_read(1'($urandom), pick_channel());
            end
            SCN_CLEAR: begin
               send_item(CMD_CLEAR, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom),
                         1'($urandom), RCH_W'($urandom));
               repeat ($urandom_range(1, 3)) send_read(1'($urandom), pick_channel());
            end
            SCN_READS: begin
               repeat ($urandom_range(2, 8)) send_read(1'($urandom), pick_channel());
            end
            default: begin
               // noise: ignored code or any code with every field random
               send_item($urandom_range(0, 1) ? CMD_UNUSED : CMD_W'($urandom_range(0, 3)),
                         IDX_W'($urandom), IDX_W'($urandom), 1'($urandom), 1'($urandom),
                         RCH_W'($urandom));
            end
         endcase
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d transactions: %0d apply, %0d read, %0d clear, %0d unused code",
               items_sent, applies_sent, reads_sent, clears_sent, unused_sent);
      $display("%0d read results compared against predicted sums, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
